@@ sv/cbih_pkg.sv @@
`timescale 1ns / 1ps
package cbih_pkg;

  localparam int QueueDepth = 2;
  localparam int MaxBytes   = 10;
  localparam int CntW       = 4;
  localparam int SeqW       = 8 * MaxBytes;

  typedef enum logic [1:0] {
    ACT_HEAD = 2'd0,
    ACT_NEG  = 2'd1,
    ACT_RAW  = 2'd2,
    ACT_WRAP = 2'd3
  } action_t;

  localparam logic [4:0] INFO_1B    = 5'h18;
  localparam logic [4:0] INFO_2B    = 5'h19;
  localparam logic [4:0] INFO_4B    = 5'h1a;
  localparam logic [4:0] INFO_8B    = 5'h1b;
  localparam logic [7:0] BSTR_BASE  = 8'h40;
  localparam logic [2:0] MT_UINT    = 3'd0;
  localparam logic [2:0] MT_NINT    = 3'd1;

  // one queued item: bytes left-aligned, first byte in the top lane
  typedef struct packed {
    logic [SeqW-1:0] seq;
    logic [CntW-1:0] cnt;
  } entry_t;

endpackage

@@ sv/cbor_item_head_encoder.sv @@
`timescale 1ns / 1ps
// CBOR head encoder: each accepted item becomes 0 to 10 output words, one byte
// each, with out_last on the final byte of the item. The input side classifies
// an item in the cycle it is taken and queues it; it accepts one item per cycle
// while the queue has room. The byte serializer drains one byte per cycle while
// out_ready is high, so raw bytes and single-byte heads sustain one item per
// cycle; a longer item holds the serializer until its last byte is taken. A
// negative of zero is accepted and produces no word.
module cbor_item_head_encoder #(
  parameter int QDepth = cbih_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [2:0]  in_major_type,
  input  logic [63:0] in_argument,
  input  logic [7:0]  in_raw_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last
);
  import cbih_pkg::*;

  entry_t push_entry;
  entry_t rd_entry;
  logic   push;
  logic   full;
  logic   rd_valid;
  logic   pop;

  assign in_ready = !full;

  cbih_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_major_type (in_major_type),
    .in_argument   (in_argument),
    .in_raw_byte   (in_raw_byte),
    .push          (push),
    .push_entry    (push_entry)
  );

  cbih_fifo #(.Depth(QDepth)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .rd_valid   (rd_valid),
    .pop        (pop),
    .rd_entry   (rd_entry)
  );

  cbih_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_valid  (rd_valid),
    .rd_entry  (rd_entry),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

@@ sv/cbih_front.sv @@
`timescale 1ns / 1ps
module cbih_front (
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [1:0]            in_action,
  input  logic [2:0]            in_major_type,
  input  logic [63:0]           in_argument,
  input  logic [7:0]            in_raw_byte,
  output logic                  push,
  output cbih_pkg::entry_t      push_entry
);
  import cbih_pkg::*;

  action_t         act;
  logic [63:0]     v;
  logic [2:0]      mt;
  logic [4:0]      info;
  logic [CntW-1:0] nb;
  logic [CntW-1:0] hlen;
  logic [63:0]     argb;
  logic [71:0]     head;
  logic            drop;

  assign act  = action_t'(in_action);
  assign drop = (act == ACT_NEG) && (in_argument == 64'd0);
  assign v    = (act == ACT_NEG) ? (in_argument - 64'd1) : in_argument;

  always_comb begin
    unique case (act)
      ACT_HEAD: mt = in_major_type;
      ACT_NEG:  mt = MT_NINT;
      default:  mt = MT_UINT;
    endcase
  end

  always_comb begin
    priority if (v < 64'd24) begin
      info = v[4:0];
      nb   = CntW'(0);
      argb = '0;
    end else if (v[63:8] == '0) begin
      info = INFO_1B;
      nb   = CntW'(1);
      argb = {v[7:0], 56'd0};
    end else if (v[63:16] == '0) begin
      info = INFO_2B;
      nb   = CntW'(2);
      argb = {v[15:0], 48'd0};
    end else if (v[63:32] == '0) begin
      info = INFO_4B;
      nb   = CntW'(4);
      argb = {v[31:0], 32'd0};
    end else begin
      info = INFO_8B;
      nb   = CntW'(8);
      argb = v;
    end
  end

  assign hlen = nb + CntW'(1);
  assign head = {mt, info, argb};

  always_comb begin
    unique case (act)
      ACT_RAW: begin
        push_entry.seq = {in_raw_byte, 72'd0};
        push_entry.cnt = CntW'(1);
      end
      ACT_WRAP: begin
        push_entry.seq = {BSTR_BASE + {4'd0, hlen}, head};
        push_entry.cnt = hlen + CntW'(1);
      end
      default: begin
        push_entry.seq = {head, 8'd0};
        push_entry.cnt = hlen;
      end
    endcase
  end

  // negative of zero is taken but yields no word
  assign push = in_valid && in_ready && !drop;

endmodule

@@ sv/cbih_fifo.sv @@
`timescale 1ns / 1ps
module cbih_fifo #(
  parameter int Depth = cbih_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cbih_pkg::entry_t push_entry,
  output logic             full,
  output logic             rd_valid,
  input  logic             pop,
  output cbih_pkg::entry_t rd_entry
);
  import cbih_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  entry_t        mem [Depth];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == CW'(Depth));
  assign rd_valid = (cnt_r != '0);
  assign rd_entry = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == AW'(Depth - 1)) ? '0 : wp_r + AW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == AW'(Depth - 1)) ? '0 : rp_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("queue write while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !rd_valid)) else $error("queue read while empty");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("queue count lost a write");

endmodule

@@ sv/cbih_back.sv @@
`timescale 1ns / 1ps
module cbih_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_valid,
  input  cbih_pkg::entry_t rd_entry,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_last
);
  import cbih_pkg::*;

  logic [SeqW-1:0] seq_r, seq_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            take;
  logic            free;

  assign out_valid = (cnt_r != '0);
  assign out_byte  = seq_r[SeqW-1 -: 8];
  assign out_last  = (cnt_r == CntW'(1));
  assign take      = out_valid && out_ready;
  assign free      = !out_valid || (out_last && out_ready);
  assign pop       = rd_valid && free;

  always_comb begin
    seq_nxt = seq_r;
    cnt_nxt = cnt_r;
    if (pop) begin
      seq_nxt = rd_entry.seq;
      cnt_nxt = rd_entry.cnt;
    end else if (take) begin
      seq_nxt = {seq_r[SeqW-9:0], 8'd0};
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r <= seq_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MaxBytes)) else $error("byte count out of range");
  a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (!out_valid || (out_last && out_ready)))
    else $error("load over pending word");

endmodule
